>>> rtl/rau_pkg.sv
// rau_pkg: shared types, opcodes and constants of the rational arithmetic unit
// depends on nothing
package rau_pkg;
	localparam int unsigned WordBitsDefault = 32;
	localparam int unsigned FieldBits = 32;
	localparam int unsigned WideBits = 64;

	typedef enum logic [1:0] {
		OP_NORM = 2'd0,
		OP_MUL  = 2'd1,
		OP_SUB  = 2'd2,
		OP_CMP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// payload of an input word and of a result word
	typedef struct packed {
		op_t                         op;
		logic signed [FieldBits-1:0] a_num;
		logic signed [FieldBits-1:0] a_den;
		logic signed [FieldBits-1:0] b_num;
		logic signed [FieldBits-1:0] b_den;
	} operand_t;

	typedef struct packed {
		logic signed [FieldBits-1:0] res_num;
		logic [FieldBits-2:0]        res_den;
		logic                        less;
		logic                        equal;
		logic                        greater;
		status_t                     status;
	} result_t;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,     // latch the operands
		CMD_MAG,      // sign and magnitudes of the selected operand
		CMD_RED_INIT, // x <- m, y <- d for the gcd
		CMD_REM_INIT, // start a remainder x % y
		CMD_REM_STEP, // one bit of restoring division
		CMD_REM_DONE, // x <- y, y <- remainder
		CMD_DIV_INIT, // start m / g
		CMD_DIV_M,    // last bit, m <- quotient, start d / g
		CMD_DIV_D,    // last bit, d <- quotient
		CMD_SAVE_A,   // canonical a saved
		CMD_SAVE_B,   // canonical b saved
		CMD_MUL1,     // first pair of products
		CMD_MUL2,     // second cross product
		CMD_COMBINE   // form the op's numerator and denominator
	} cmd_t;

	typedef struct packed {
		logic y_zero;
		logic step_last;
		logic zero_den;
	} dp_status_t;
endpackage

>>> rtl/rau_if.sv
// rau_if: valid/ready channel carrying one word of type word_t
// depends on nothing
interface rau_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rau_datapath.sv
// rau_datapath: operand registers, bit-serial divider and multiplier stages
// depends on rau_pkg
module rau_datapath #(
	parameter int unsigned WORD_BITS = rau_pkg::WordBitsDefault
) (
	input  logic                            clk,
	input  rau_pkg::cmd_t                   cmd,
	input  logic [1:0]                      op,
	input  logic [rau_pkg::FieldBits-1:0]   a_num,
	input  logic [rau_pkg::FieldBits-1:0]   a_den,
	input  logic [rau_pkg::FieldBits-1:0]   b_num,
	input  logic [rau_pkg::FieldBits-1:0]   b_den,
	input  logic                            sel_b,
	output rau_pkg::dp_status_t             st,
	output logic [rau_pkg::FieldBits-1:0]   res_num,
	output logic [rau_pkg::FieldBits-2:0]   res_den,
	output logic                            less,
	output logic                            equal,
	output logic                            greater,
	output logic                            ovf
);
	localparam int unsigned W = rau_pkg::WideBits;
	localparam int unsigned FB = rau_pkg::FieldBits;
	localparam int unsigned CW = $clog2(W);
	localparam logic [W-1:0] Lim = (W'(1) << (WORD_BITS - 1)) - W'(1);

	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic [1:0] op_q;
	logic neg_q;
	logic [W-1:0] m_q, d_q, x_q, y_q;
	logic [W-1:0] rem_q, quo_q, dvd_q, dvs_q;
	logic [CW-1:0] cnt_q;
	// canonical numerators reach 2^31 in magnitude, so they carry one extra bit
	logic [FB:0] can_an_q, can_bn_q;
	logic [FB-1:0] can_ad_q, can_bd_q;
	logic [W-1:0] p1_q, p2_q, p3_q;
	logic [W-1:0] rem_sh, rem_sub, quo_nxt;
	logic rem_ge;
	logic signed [W-1:0] san, sad, sbn, sbd, sel_n, sel_d;
	logic signed [W-1:0] dn;

	assign san = $signed(an_q);
	assign sad = $signed(ad_q);
	assign sbn = $signed(bn_q);
	assign sbd = $signed(bd_q);
	assign sel_n = sel_b ? sbn : san;
	assign sel_d = sel_b ? sbd : sad;

	assign rem_sh = {rem_q[W-2:0], dvd_q[W-1]};
	assign rem_ge = (rem_sh >= dvs_q) || rem_q[W-1];
	assign rem_sub = rem_sh - dvs_q;
	assign quo_nxt = {quo_q[W-2:0], rem_ge};
	assign dn = $signed(p1_q) - $signed(p2_q);

	assign st.y_zero = (y_q == '0);
	assign st.step_last = (cnt_q == CW'(W - 1));
	assign st.zero_den = (ad_q == '0) || (op_q != rau_pkg::OP_NORM && bd_q == '0);

	always_ff @(posedge clk) begin
		case (cmd)
			rau_pkg::CMD_LOAD: begin
				op_q <= op;
				an_q <= W'($signed(a_num));
				ad_q <= W'($signed(a_den));
				bn_q <= W'($signed(b_num));
				bd_q <= W'($signed(b_den));
			end
			rau_pkg::CMD_MAG: begin
				// operand magnitudes for canonicalisation, chosen by sel_b
				neg_q <= (sel_n < 0) != (sel_d < 0);
				m_q <= sel_n[W-1] ? W'(0) - W'(sel_n) : W'(sel_n);
				d_q <= sel_d[W-1] ? W'(0) - W'(sel_d) : W'(sel_d);
			end
			rau_pkg::CMD_RED_INIT: begin
				x_q <= m_q;
				y_q <= d_q;
			end
			rau_pkg::CMD_REM_INIT: begin
				dvd_q <= x_q;
				dvs_q <= y_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			rau_pkg::CMD_DIV_INIT: begin
				dvd_q <= m_q;
				dvs_q <= (x_q == '0) ? W'(1) : x_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			rau_pkg::CMD_REM_STEP: begin
				rem_q <= rem_ge ? rem_sub : rem_sh;
				quo_q <= quo_nxt;
				dvd_q <= {dvd_q[W-2:0], 1'b0};
				cnt_q <= cnt_q + CW'(1);
			end
			rau_pkg::CMD_REM_DONE: begin
				x_q <= y_q;
				y_q <= rem_q;
			end
			rau_pkg::CMD_DIV_M: begin
				m_q <= quo_nxt;
				dvd_q <= d_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			rau_pkg::CMD_DIV_D: d_q <= quo_nxt;
			rau_pkg::CMD_SAVE_A: begin
				can_an_q <= (m_q == '0) ? '0 :
					(neg_q ? (FB+1)'(W'(0) - m_q) : (FB+1)'(m_q));
				can_ad_q <= (m_q == '0) ? FB'(1) : FB'(d_q);
			end
			rau_pkg::CMD_SAVE_B: begin
				can_bn_q <= (m_q == '0) ? '0 :
					(neg_q ? (FB+1)'(W'(0) - m_q) : (FB+1)'(m_q));
				can_bd_q <= (m_q == '0) ? FB'(1) : FB'(d_q);
			end
			rau_pkg::CMD_MUL1: begin
				if (op_q == rau_pkg::OP_MUL) begin
					p1_q <= W'($signed(can_an_q) * $signed(can_bn_q));
				end else begin
					p1_q <= W'($signed(can_an_q) * $signed({1'b0, can_bd_q}));
				end
				p3_q <= W'(can_ad_q) * W'(can_bd_q);
			end
			rau_pkg::CMD_MUL2: begin
				p2_q <= W'($signed({1'b0, can_ad_q}) * $signed(can_bn_q));
			end
			rau_pkg::CMD_COMBINE: begin
				if (op_q == rau_pkg::OP_MUL) begin
					neg_q <= p1_q[W-1];
					m_q <= p1_q[W-1] ? W'(0) - p1_q : p1_q;
				end else begin
					neg_q <= dn[W-1];
					m_q <= dn[W-1] ? W'(0) - W'(dn) : W'(dn);
				end
				d_q <= p3_q;
			end
			default: begin
			end
		endcase
	end

	// final result taken from the reduced value, or cross products for compare
	assign ovf = (m_q > Lim) || (d_q > Lim);
	assign res_num = (m_q == '0) ? '0 :
		(neg_q ? FB'(W'(0) - m_q) : FB'(m_q));
	assign res_den = (m_q == '0) ? (FB-1)'(1) : (FB-1)'(d_q);
	assign less = $signed(p1_q) < $signed(p2_q);
	assign equal = p1_q == p2_q;
	assign greater = $signed(p1_q) > $signed(p2_q);
endmodule

>>> rtl/rau_ctrl.sv
// rau_ctrl: sequencer issuing datapath commands for one word at a time
// depends on rau_pkg
module rau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rau_pkg::dp_status_t st,
	input  logic [1:0]          op,
	input  logic                ovf,
	output rau_pkg::cmd_t       cmd,
	output logic                sel_b,
	output logic                load_res,
	output rau_pkg::status_t    res_status,
	output logic                res_cmp
);
	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_MAG, S_RINIT, S_GTEST, S_RSTEP, S_RDONE,
		S_DSTEP_M, S_DSTEP_D, S_DDONE, S_MUL1, S_MUL2, S_COMB, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] stage_q; // 0 a, 1 b, 2 result

	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);

	always_comb begin
		cmd = rau_pkg::CMD_NONE;
		sel_b = stage_q[0];
		load_res = 1'b0;
		case (state_q)
			S_IDLE, S_OUT: cmd = (in_valid && in_ready) ? rau_pkg::CMD_LOAD : rau_pkg::CMD_NONE;
			S_CHECK: cmd = rau_pkg::CMD_NONE;
			S_MAG: cmd = rau_pkg::CMD_MAG;
			S_RINIT: cmd = rau_pkg::CMD_RED_INIT;
			S_GTEST: cmd = st.y_zero ? rau_pkg::CMD_DIV_INIT : rau_pkg::CMD_REM_INIT;
			S_RSTEP, S_DSTEP_M, S_DSTEP_D: cmd = rau_pkg::CMD_REM_STEP;
			S_RDONE: cmd = rau_pkg::CMD_REM_DONE;
			S_DDONE: cmd = (stage_q == 2'd0) ? rau_pkg::CMD_SAVE_A :
				(stage_q == 2'd1) ? rau_pkg::CMD_SAVE_B : rau_pkg::CMD_NONE;
			S_MUL1: cmd = rau_pkg::CMD_MUL1;
			S_MUL2: cmd = rau_pkg::CMD_MUL2;
			S_COMB: cmd = rau_pkg::CMD_COMBINE;
			S_FIN: load_res = 1'b1;
			default: cmd = rau_pkg::CMD_NONE;
		endcase
		if (state_q == S_DSTEP_M && st.step_last) cmd = rau_pkg::CMD_DIV_M;
		if (state_q == S_DSTEP_D && st.step_last) cmd = rau_pkg::CMD_DIV_D;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			stage_q <= 2'd0;
			res_status <= rau_pkg::ST_OK;
			res_cmp <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE, S_OUT: begin
					if (state_q == S_OUT && out_ready) state_q <= S_IDLE;
					if (in_valid && in_ready) begin
						state_q <= S_CHECK;
						stage_q <= 2'd0;
					end
				end
				S_CHECK: begin
					if (st.zero_den) begin
						res_status <= rau_pkg::ST_ZERO_DEN;
						res_cmp <= 1'b0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_MAG;
					end
				end
				S_MAG: state_q <= S_RINIT;
				S_RINIT: state_q <= S_GTEST;
				S_GTEST: state_q <= st.y_zero ? S_DSTEP_M : S_RSTEP;
				S_RSTEP: if (st.step_last) state_q <= S_RDONE;
				S_RDONE: state_q <= S_GTEST;
				S_DSTEP_M: if (st.step_last) state_q <= S_DSTEP_D;
				S_DSTEP_D: if (st.step_last) state_q <= S_DDONE;
				S_DDONE: begin
					if (stage_q == 2'd0 && op != rau_pkg::OP_NORM) begin
						stage_q <= 2'd1;
						state_q <= S_MAG;
					end else if (stage_q == 2'd2 || op == rau_pkg::OP_NORM) begin
						res_status <= ovf ? rau_pkg::ST_OVERFLOW : rau_pkg::ST_OK;
						res_cmp <= 1'b0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: begin
					if (op == rau_pkg::OP_CMP) begin
						res_status <= rau_pkg::ST_OK;
						res_cmp <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_COMB;
					end
				end
				S_COMB: begin
					stage_q <= 2'd2;
					state_q <= S_RINIT;
				end
				S_FIN: begin
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> out_valid)
		else $error("result not presented after finish");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_OUT))
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && res_cmp) |-> (res_status == rau_pkg::ST_OK))
		else $error("compare flagged an error");
endmodule

>>> rtl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level joining sequencer and datapath
// depends on rau_pkg, rau_if, rau_ctrl, rau_datapath
//
// One word at a time. After a word is taken the denominator of a, and of b unless
// normalising, is checked; then each operand in use is brought to lowest terms and,
// for multiply and subtract, the combined result is reduced once more. Every
// reduction runs the Euclidean gcd on one shared bit-serial remainder unit; each
// remainder step is a set-up, a shift-subtract over all 64 bits and a swap, and two
// divisions by the gcd follow. A zero denominator skips the reduction and goes
// straight to the output. The result sits in the output register until taken, and
// a new word is accepted in the same cycle the result leaves.
module rational_arithmetic_unit #(
	parameter int unsigned WORD_BITS = rau_pkg::WordBitsDefault
) (
	input logic clk,
	input logic arst_n,
	rau_if.sink   in,
	rau_if.source out
);
	rau_pkg::cmd_t cmd;
	rau_pkg::dp_status_t st;
	rau_pkg::status_t res_status;
	logic sel_b, load_res, res_cmp, ovf;
	logic [rau_pkg::FieldBits-1:0] d_num;
	logic [rau_pkg::FieldBits-2:0] d_den;
	logic d_less, d_equal, d_greater;
	logic [1:0] op_q;

	// hold op of the word in flight for the sequencer
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) op_q <= in.data.op;
	end

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.st(st), .op(op_q), .ovf(ovf), .cmd(cmd), .sel_b(sel_b),
		.load_res(load_res), .res_status(res_status), .res_cmp(res_cmp)
	);

	// overflow limit follows WORD_BITS, the fields stay at full width
	rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
		.clk(clk), .cmd(cmd), .op(in.data.op),
		.a_num(in.data.a_num), .a_den(in.data.a_den),
		.b_num(in.data.b_num), .b_den(in.data.b_den),
		.sel_b(sel_b), .st(st),
		.res_num(d_num), .res_den(d_den),
		.less(d_less), .equal(d_equal), .greater(d_greater), .ovf(ovf)
	);

	// output word register
	always_ff @(posedge clk) begin
		if (load_res) begin
			out.data.status <= res_status;
			if (res_status == rau_pkg::ST_OK && !res_cmp) begin
				out.data.res_num <= d_num;
				out.data.res_den <= d_den;
			end else begin
				out.data.res_num <= '0;
				out.data.res_den <= (rau_pkg::FieldBits-1)'(1);
			end
			out.data.less <= res_cmp & d_less;
			out.data.equal <= res_cmp & d_equal;
			out.data.greater <= res_cmp & d_greater;
		end
	end
endmodule
